// File: sv/ppp_pkg.sv
// Shared constants and types for the pinhole point projection block.
package ppp_pkg;

    localparam int COORD_W  = 24;   // Q16.8 world and config coordinates
    localparam int ROT_W    = 16;   // Q2.14 matrix entry
    localparam int PROD_W   = COORD_W + ROT_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int FRAC_SH  = 14;
    localparam int CAM_W    = ACC_W - FRAC_SH;
    localparam int NUM_W    = COORD_W + CAM_W;
    localparam int DIV_BITS = 34;   // quotient bits kept; larger quotients always saturate
    localparam int HEAD_W   = NUM_W - DIV_BITS;
    localparam int OUT_W    = 32;
    localparam int SUM_W    = DIV_BITS + 2;
    localparam int REG_W    = 48;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;

    localparam logic [REG_W-1:0]   ROT0_RST  = 48'h4000_0000_0000;
    localparam logic [REG_W-1:0]   ROT1_RST  = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0]   ROT2_RST  = 48'h0000_0000_4000;
    localparam logic [COORD_W-1:0] SHXY_RST  = 24'd204800;
    localparam logic [COORD_W-1:0] SHZ_RST   = 24'd128000;
    localparam logic [REG_W-1:0]   FOCAL_RST = {24'd102400, 24'd102400};
    localparam logic [REG_W-1:0]   PP_RST    = {24'd131072, 24'd131072};

    typedef enum logic [2:0] {
        REG_ROT0  = 3'd0,
        REG_ROT1  = 3'd1,
        REG_ROT2  = 3'd2,
        REG_SHX   = 3'd3,
        REG_SHY   = 3'd4,
        REG_SHZ   = 3'd5,
        REG_FOCAL = 3'd6,
        REG_PP    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

endpackage

// File: sv/pinhole_point_projection.sv
// Pinhole point projection: rotate, translate, divide by depth, scale and offset.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------
//  input   | s_world_x, s_world_y, s_world_z         | s_valid/s_ready
//  result  | m_image_u, m_image_v, m_projection_status| m_valid/m_ready
//  config  | psel, penable, pwrite, paddr, pwdata    | pready (always 1)
//
// One beat in per cycle while the output is not stalled.
// The restoring divider has 34 stages, one quotient bit per stage.
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module pinhole_point_projection (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ppp_pkg::ADDR_W-1:0]             paddr,
    input  logic [ppp_pkg::DATA_W-1:0]             pwdata,
    output logic [ppp_pkg::DATA_W-1:0]             prdata,
    output logic                                   pready,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [ppp_pkg::COORD_W-1:0]     s_world_x,
    input  logic signed [ppp_pkg::COORD_W-1:0]     s_world_y,
    input  logic signed [ppp_pkg::COORD_W-1:0]     s_world_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ppp_pkg::OUT_W-1:0]       m_image_u,
    output logic signed [ppp_pkg::OUT_W-1:0]       m_image_v,
    output logic [1:0]                             m_projection_status
);

    typedef struct packed {
        logic [ppp_pkg::CAM_W-1:0]    rem;
        logic [ppp_pkg::DIV_BITS-1:0] num;
        logic [ppp_pkg::DIV_BITS-1:0] quo;
        logic                         neg;
        logic                         ovf;
        logic                         csign;
    } lane_t;

    typedef struct packed {
        lane_t [1:0]               lane;
        logic [ppp_pkg::CAM_W-1:0] den;
        logic                      zero;
    } dstage_t;

    function automatic lane_t div_step(input lane_t a, input logic [ppp_pkg::CAM_W-1:0] den);
        lane_t                     r;
        logic [ppp_pkg::CAM_W:0]   trial;
        logic                      bit_q;
        r     = a;
        trial = {a.rem, a.num[ppp_pkg::DIV_BITS-1]};
        bit_q = (trial >= {1'b0, den});
        if (bit_q) begin
            trial = trial - {1'b0, den};
        end
        r.rem = trial[ppp_pkg::CAM_W-1:0];
        r.num = {a.num[ppp_pkg::DIV_BITS-2:0], 1'b0};
        r.quo = {a.quo[ppp_pkg::DIV_BITS-2:0], bit_q};
        return r;
    endfunction

    // configuration registers
    logic [ppp_pkg::REG_W-1:0]          rot_reg [3];
    logic signed [ppp_pkg::COORD_W-1:0] shift_reg [3];
    logic [ppp_pkg::REG_W-1:0]          focal_reg;
    logic [ppp_pkg::REG_W-1:0]          pp_reg;

    logic adv;
    logic cfg_wr;
    ppp_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = ppp_pkg::reg_idx_t'(paddr[ppp_pkg::ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0]   <= ppp_pkg::ROT0_RST;
            rot_reg[1]   <= ppp_pkg::ROT1_RST;
            rot_reg[2]   <= ppp_pkg::ROT2_RST;
            shift_reg[0] <= ppp_pkg::SHXY_RST;
            shift_reg[1] <= ppp_pkg::SHXY_RST;
            shift_reg[2] <= ppp_pkg::SHZ_RST;
            focal_reg    <= ppp_pkg::FOCAL_RST;
            pp_reg       <= ppp_pkg::PP_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                ppp_pkg::REG_ROT0:  rot_reg[0]   <= pwdata[ppp_pkg::REG_W-1:0];
                ppp_pkg::REG_ROT1:  rot_reg[1]   <= pwdata[ppp_pkg::REG_W-1:0];
                ppp_pkg::REG_ROT2:  rot_reg[2]   <= pwdata[ppp_pkg::REG_W-1:0];
                ppp_pkg::REG_SHX:   shift_reg[0] <= pwdata[ppp_pkg::COORD_W-1:0];
                ppp_pkg::REG_SHY:   shift_reg[1] <= pwdata[ppp_pkg::COORD_W-1:0];
                ppp_pkg::REG_SHZ:   shift_reg[2] <= pwdata[ppp_pkg::COORD_W-1:0];
                ppp_pkg::REG_FOCAL: focal_reg    <= pwdata[ppp_pkg::REG_W-1:0];
                ppp_pkg::REG_PP:    pp_reg       <= pwdata[ppp_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            ppp_pkg::REG_ROT0:  prdata = {16'd0, rot_reg[0]};
            ppp_pkg::REG_ROT1:  prdata = {16'd0, rot_reg[1]};
            ppp_pkg::REG_ROT2:  prdata = {16'd0, rot_reg[2]};
            ppp_pkg::REG_SHX:   prdata = {40'd0, shift_reg[0]};
            ppp_pkg::REG_SHY:   prdata = {40'd0, shift_reg[1]};
            ppp_pkg::REG_SHZ:   prdata = {40'd0, shift_reg[2]};
            ppp_pkg::REG_FOCAL: prdata = {16'd0, focal_reg};
            ppp_pkg::REG_PP:    prdata = {16'd0, pp_reg};
            default:            prdata = '0;
        endcase
    end

    // pipeline registers
    logic                                v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic [ppp_pkg::DIV_BITS:0]          dv_reg;
    logic signed [ppp_pkg::PROD_W-1:0]   prod_reg [3][3];
    logic signed [ppp_pkg::PROD_W-1:0]   prod_next [3][3];
    logic signed [ppp_pkg::CAM_W-1:0]    cam_reg [3];
    logic signed [ppp_pkg::CAM_W-1:0]    cam_next [3];
    logic signed [ppp_pkg::NUM_W-1:0]    num_reg [2];
    logic signed [ppp_pkg::NUM_W-1:0]    num_next [2];
    logic signed [ppp_pkg::CAM_W-1:0]    cz3_reg;
    logic [1:0]                          csign3_reg;
    logic [ppp_pkg::NUM_W-1:0]           un_reg [2];
    logic [ppp_pkg::NUM_W-1:0]           un_next [2];
    logic [ppp_pkg::CAM_W-1:0]           ud_reg;
    logic [ppp_pkg::CAM_W-1:0]           ud_next;
    logic [1:0]                          neg4_reg;
    logic [1:0]                          csign4_reg;
    logic                                zero4_reg;
    dstage_t                             ds_reg [ppp_pkg::DIV_BITS+1];
    dstage_t                             ds_next [ppp_pkg::DIV_BITS+1];
    logic signed [ppp_pkg::OUT_W-1:0]    u_reg, v_reg;
    logic signed [ppp_pkg::OUT_W-1:0]    u_next, v_next;
    logic [1:0]                          st_reg, st_next;

    logic signed [ppp_pkg::COORD_W-1:0]  w [3];
    logic signed [ppp_pkg::ACC_W-1:0]    acc [3];

    assign adv     = ~m_valid_reg | m_ready;
    assign s_ready = adv;
    assign w[0]    = s_world_x;
    assign w[1]    = s_world_y;
    assign w[2]    = s_world_z;

    // stage 1: products, stage 2: sums rounded to Q.8
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = $signed(rot_reg[i][ppp_pkg::REG_W-1-ppp_pkg::ROT_W*j -:
                                                    ppp_pkg::ROT_W]) * w[j];
            end
            acc[i] = ppp_pkg::ACC_W'(prod_reg[i][0]) + ppp_pkg::ACC_W'(prod_reg[i][1])
                   + ppp_pkg::ACC_W'(prod_reg[i][2])
                   + (ppp_pkg::ACC_W'(shift_reg[i]) <<< ppp_pkg::FRAC_SH)
                   + ppp_pkg::ACC_W'(1 << (ppp_pkg::FRAC_SH - 1));
            cam_next[i] = acc[i][ppp_pkg::ACC_W-1:ppp_pkg::FRAC_SH];
        end
    end

    // stage 3: numerators, stage 4: magnitudes with half divisor added for rounding
    always_comb begin
        num_next[0] = $signed({1'b0, focal_reg[2*ppp_pkg::COORD_W-1:ppp_pkg::COORD_W]})
                    * cam_reg[0];
        num_next[1] = $signed({1'b0, focal_reg[ppp_pkg::COORD_W-1:0]}) * cam_reg[1];
        ud_next     = cz3_reg[ppp_pkg::CAM_W-1] ? ppp_pkg::CAM_W'(-cz3_reg)
                                                 : ppp_pkg::CAM_W'(cz3_reg);
        for (int i = 0; i < 2; i++) begin
            un_next[i] = (num_reg[i][ppp_pkg::NUM_W-1] ? ppp_pkg::NUM_W'(-num_reg[i])
                                                         : ppp_pkg::NUM_W'(num_reg[i]))
                       + ppp_pkg::NUM_W'(ud_next >> 1);
        end
    end

    // stage 5: overflow test and divider load; then one quotient bit per stage
    always_comb begin
        ds_next[0].den  = ud_reg;
        ds_next[0].zero = zero4_reg;
        for (int i = 0; i < 2; i++) begin
            ds_next[0].lane[i].rem   = ppp_pkg::CAM_W'(un_reg[i][ppp_pkg::NUM_W-1:ppp_pkg::DIV_BITS]);
            ds_next[0].lane[i].num   = un_reg[i][ppp_pkg::DIV_BITS-1:0];
            ds_next[0].lane[i].quo   = '0;
            ds_next[0].lane[i].neg   = neg4_reg[i];
            ds_next[0].lane[i].csign = csign4_reg[i];
            ds_next[0].lane[i].ovf   = (ppp_pkg::CAM_W'(un_reg[i][ppp_pkg::NUM_W-1:
                                        ppp_pkg::DIV_BITS]) >= ud_reg);
        end
        for (int k = 1; k <= ppp_pkg::DIV_BITS; k++) begin
            ds_next[k] = ds_reg[k-1];
            for (int i = 0; i < 2; i++) begin
                ds_next[k].lane[i] = div_step(ds_reg[k-1].lane[i], ds_reg[k-1].den);
            end
        end
    end

    // final stage: sign, principal point, clamp
    logic signed [ppp_pkg::SUM_W-1:0] sq [2];
    logic signed [ppp_pkg::SUM_W-1:0] rs [2];
    logic signed [ppp_pkg::OUT_W-1:0] res [2];
    logic [1:0]                        sat;
    lane_t                             fl [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            fl[i] = ds_reg[ppp_pkg::DIV_BITS].lane[i];
            sq[i] = fl[i].neg ? -$signed({2'b00, fl[i].quo}) : $signed({2'b00, fl[i].quo});
            rs[i] = sq[i] + $signed({12'd0, pp_reg[ppp_pkg::COORD_W*(2-i)-1 -: ppp_pkg::COORD_W]});
            sat[i] = 1'b1;
            if (fl[i].ovf) begin
                res[i] = fl[i].neg ? {1'b1, {(ppp_pkg::OUT_W-1){1'b0}}}
                                   : {1'b0, {(ppp_pkg::OUT_W-1){1'b1}}};
            end else if (rs[i][ppp_pkg::SUM_W-1:ppp_pkg::OUT_W-1]
                         != {(ppp_pkg::SUM_W-ppp_pkg::OUT_W+1){rs[i][ppp_pkg::SUM_W-1]}}) begin
                // sign bits disagree: clamp towards the sign of the sum
                res[i] = rs[i][ppp_pkg::SUM_W-1] ? {1'b1, {(ppp_pkg::OUT_W-1){1'b0}}}
                                                 : {1'b0, {(ppp_pkg::OUT_W-1){1'b1}}};
            end else begin
                res[i] = rs[i][ppp_pkg::OUT_W-1:0];
                sat[i] = 1'b0;
            end
        end
        if (ds_reg[ppp_pkg::DIV_BITS].zero) begin
            u_next  = fl[0].csign ? {1'b1, {(ppp_pkg::OUT_W-1){1'b0}}}
                                  : {1'b0, {(ppp_pkg::OUT_W-1){1'b1}}};
            v_next  = fl[1].csign ? {1'b1, {(ppp_pkg::OUT_W-1){1'b0}}}
                                  : {1'b0, {(ppp_pkg::OUT_W-1){1'b1}}};
            st_next = ppp_pkg::ST_ZERO;
        end else begin
            u_next  = res[0];
            v_next  = res[1];
            st_next = (|sat) ? ppp_pkg::ST_SAT : ppp_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            dv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            dv_reg      <= {dv_reg[ppp_pkg::DIV_BITS-1:0], v4_reg};
            m_valid_reg <= dv_reg[ppp_pkg::DIV_BITS];
        end
    end

    // payload advances with the valid bits; no reset needed
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg   <= prod_next;
            cam_reg    <= cam_next;
            num_reg    <= num_next;
            cz3_reg    <= cam_reg[2];
            csign3_reg <= {cam_reg[1][ppp_pkg::CAM_W-1], cam_reg[0][ppp_pkg::CAM_W-1]};
            un_reg     <= un_next;
            ud_reg     <= ud_next;
            neg4_reg   <= {num_reg[1][ppp_pkg::NUM_W-1] ^ cz3_reg[ppp_pkg::CAM_W-1],
                           num_reg[0][ppp_pkg::NUM_W-1] ^ cz3_reg[ppp_pkg::CAM_W-1]};
            csign4_reg <= csign3_reg;
            zero4_reg  <= (cz3_reg == '0);
            ds_reg     <= ds_next;
            u_reg      <= u_next;
            v_reg      <= v_next;
            st_reg     <= st_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_image_u           = u_reg;
    assign m_image_v           = v_reg;
    assign m_projection_status = st_reg;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the pinhole point projection block.
`timescale 1ns / 100ps

module testbench;

    localparam int  DRAIN_CYCLES = 60;
    localparam int  STALL_LIMIT  = 5000;
    localparam int  RANDOM_ITEMS = 1600;
    localparam longint SAT_HI    = 64'sd2147483647;
    localparam longint SAT_LO    = -64'sd2147483648;

    typedef struct packed {
        logic signed [ppp_pkg::COORD_W-1:0] x;
        logic signed [ppp_pkg::COORD_W-1:0] y;
        logic signed [ppp_pkg::COORD_W-1:0] z;
    } world_pt_t;

    typedef struct packed {
        logic signed [ppp_pkg::OUT_W-1:0] u;
        logic signed [ppp_pkg::OUT_W-1:0] v;
        ppp_pkg::status_t                 st;
    } image_pt_t;

    logic                                   aclk = 1'b0;
    logic                                   aresetn = 1'b0;
    logic                                   psel = 1'b0;
    logic                                   penable = 1'b0;
    logic                                   pwrite = 1'b0;
    logic [ppp_pkg::ADDR_W-1:0]             paddr = '0;
    logic [ppp_pkg::DATA_W-1:0]             pwdata = '0;
    logic [ppp_pkg::DATA_W-1:0]             prdata;
    logic                                   pready;
    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic signed [ppp_pkg::COORD_W-1:0]     s_world_x = '0;
    logic signed [ppp_pkg::COORD_W-1:0]     s_world_y = '0;
    logic signed [ppp_pkg::COORD_W-1:0]     s_world_z = '0;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic signed [ppp_pkg::OUT_W-1:0]       m_image_u;
    logic signed [ppp_pkg::OUT_W-1:0]       m_image_v;
    logic [1:0]                             m_projection_status;

    pinhole_point_projection dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [ppp_pkg::REG_W-1:0] cam_regs [8];
    world_pt_t                 pending_points[$];
    image_pt_t                 expected_images[$];
    int                        mismatches = 0;
    int                        idle_cycles = 0;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Camera coordinate in Q.8: exact Q.22 sum, then round half up.
    function automatic longint cam_axis(input logic [ppp_pkg::REG_W-1:0] row,
                                        input logic [ppp_pkg::REG_W-1:0] shift,
                                        input world_pt_t p);
        longint acc;
        acc = longint'($signed(shift[ppp_pkg::COORD_W-1:0])) * 16384;
        acc += longint'($signed(row[47:32])) * longint'(p.x);
        acc += longint'($signed(row[31:16])) * longint'(p.y);
        acc += longint'($signed(row[15:0]))  * longint'(p.z);
        return (acc + 8192) >>> ppp_pkg::FRAC_SH;
    endfunction

    // Divide, rounding to nearest with ties away from zero.
    function automatic longint div_round(input longint n, input longint d);
        longint an, ad, q;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q  = (an + ad / 2) / ad;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic image_pt_t project_point(input world_pt_t p);
        longint cx, cy, cz, u, v;
        image_pt_t r;
        cx = cam_axis(cam_regs[ppp_pkg::REG_ROT0], cam_regs[ppp_pkg::REG_SHX], p);
        cy = cam_axis(cam_regs[ppp_pkg::REG_ROT1], cam_regs[ppp_pkg::REG_SHY], p);
        cz = cam_axis(cam_regs[ppp_pkg::REG_ROT2], cam_regs[ppp_pkg::REG_SHZ], p);
        if (cz == 0) begin
            u = cx < 0 ? SAT_LO : SAT_HI;
            v = cy < 0 ? SAT_LO : SAT_HI;
            r.st = ppp_pkg::ST_ZERO;
        end else begin
            u = div_round(longint'(cam_regs[ppp_pkg::REG_FOCAL][47:24]) * cx, cz)
                + longint'(cam_regs[ppp_pkg::REG_PP][47:24]);
            v = div_round(longint'(cam_regs[ppp_pkg::REG_FOCAL][23:0]) * cy, cz)
                + longint'(cam_regs[ppp_pkg::REG_PP][23:0]);
            r.st = ppp_pkg::ST_OK;
            if (u > SAT_HI || u < SAT_LO || v > SAT_HI || v < SAT_LO)
                r.st = ppp_pkg::ST_SAT;
            u = u > SAT_HI ? SAT_HI : (u < SAT_LO ? SAT_LO : u);
            v = v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
        end
        r.u = u[ppp_pkg::OUT_W-1:0];
        r.v = v[ppp_pkg::OUT_W-1:0];
        return r;
    endfunction

    // Input driver: per-beat gap, with bursts of back-to-back beats.
    int  src_gap = 0;
    bit  src_burst = 1'b0;
    always @(posedge aclk) begin
        world_pt_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid)
                expected_images = {expected_images,
                                   project_point({s_world_x, s_world_y, s_world_z})};
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                p = pending_points.pop_front();
                s_world_x <= p.x;
                s_world_y <= p.y;
                s_world_z <= p.z;
                s_valid   <= 1'b1;
                if ($urandom_range(0, 40) == 0)
                    src_burst <= !src_burst;
                src_gap <= src_burst ? 0 : $urandom_range(0, 11);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each beat with the oldest expectation.
    int  sink_stall = 0;
    bit  sink_burst = 1'b0;
    always @(posedge aclk) begin
        image_pt_t e;
        int ns;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            ns = sink_stall > 0 ? sink_stall - 1 : 0;
            if (m_valid && m_ready) begin
                if (expected_images.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    e = expected_images.pop_front();
                    if (m_image_u !== e.u)
                        report($sformatf("image_u %0d, expected %0d", m_image_u, e.u));
                    if (m_image_v !== e.v)
                        report($sformatf("image_v %0d, expected %0d", m_image_v, e.v));
                    if (m_projection_status !== e.st)
                        report($sformatf("status %0d, expected %0d",
                                         m_projection_status, e.st));
                end
                if ($urandom_range(0, 40) == 0)
                    sink_burst <= !sink_burst;
                ns = sink_burst ? 0 : $urandom_range(0, 11);
            end
            sink_stall <= ns;
            m_ready    <= (ns == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("pinhole_point_projection test failed");
            $finish;
        end
    end

    task automatic write_reg(input ppp_pkg::reg_idx_t idx,
                             input logic [ppp_pkg::REG_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ppp_pkg::ADDR_W'(8 * int'(idx));
        pwdata  <= ppp_pkg::DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ppp_pkg::REG_SHX || idx == ppp_pkg::REG_SHY || idx == ppp_pkg::REG_SHZ)
            cam_regs[idx] = {24'd0, val[ppp_pkg::COORD_W-1:0]};
        else
            cam_regs[idx] = val;
    endtask

    task automatic write_all(input logic [ppp_pkg::REG_W-1:0] r0, r1, r2,
                             input logic [ppp_pkg::REG_W-1:0] sx, sy, sz, f, pp);
        write_reg(ppp_pkg::REG_ROT0, r0);
        write_reg(ppp_pkg::REG_ROT1, r1);
        write_reg(ppp_pkg::REG_ROT2, r2);
        write_reg(ppp_pkg::REG_SHX, sx);
        write_reg(ppp_pkg::REG_SHY, sy);
        write_reg(ppp_pkg::REG_SHZ, sz);
        write_reg(ppp_pkg::REG_FOCAL, f);
        write_reg(ppp_pkg::REG_PP, pp);
    endtask

    // Wait until every result is back, then let the pipeline drain.
    task automatic drain();
        while (pending_points.size() > 0 || s_valid || expected_images.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [ppp_pkg::REG_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [ppp_pkg::REG_W-1:0] rand_focal();
        return {8'd0, 16'($urandom), 8'd0, 16'($urandom)};
    endfunction

    task automatic add_point(input int x, y, z);
        world_pt_t p;
        p = {24'(x), 24'(y), 24'(z)};
        pending_points = {pending_points, p};
    endtask

    // Mostly moderate coordinates, some full range, some near the depth plane.
    task automatic add_random_points(input int n);
        int k, z0;
        for (int i = 0; i < n; i++) begin
            k  = $urandom_range(0, 9);
            z0 = -int'($signed(cam_regs[ppp_pkg::REG_SHZ][ppp_pkg::COORD_W-1:0]));
            if (k < 3)
                add_point($urandom, $urandom, $urandom);
            else if (k < 5)
                add_point($urandom, $urandom, z0 + $urandom_range(0, 4) - 2);
            else
                add_point($urandom_range(0, 1 << 18) - (1 << 17),
                          $urandom_range(0, 1 << 18) - (1 << 17),
                          $urandom_range(0, 1 << 18) - (1 << 17));
        end
    endtask

    initial begin
        cam_regs[ppp_pkg::REG_ROT0]  = ppp_pkg::ROT0_RST;
        cam_regs[ppp_pkg::REG_ROT1]  = ppp_pkg::ROT1_RST;
        cam_regs[ppp_pkg::REG_ROT2]  = ppp_pkg::ROT2_RST;
        cam_regs[ppp_pkg::REG_SHX]   = ppp_pkg::REG_W'(ppp_pkg::SHXY_RST);
        cam_regs[ppp_pkg::REG_SHY]   = ppp_pkg::REG_W'(ppp_pkg::SHXY_RST);
        cam_regs[ppp_pkg::REG_SHZ]   = ppp_pkg::REG_W'(ppp_pkg::SHZ_RST);
        cam_regs[ppp_pkg::REG_FOCAL] = ppp_pkg::FOCAL_RST;
        cam_regs[ppp_pkg::REG_PP]    = ppp_pkg::PP_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, depth plane on both sides, overflow.
        add_point(0, 0, 0);
        add_point(8388607, 8388607, 8388607);
        add_point(-8388608, -8388608, -8388608);
        add_point(8388607, -8388608, 0);
        add_point(-8388608, 8388607, 256);
        add_point(0, 0, -128000);
        add_point(-256, -256, -128000);
        add_point(256, -256, -128000);
        add_point(-204800, -204800, -128000);
        add_point(8388607, 8388607, -127999);
        add_point(-8388608, 8388607, -128001);
        add_point(1000, -1000, -200000);
        add_point(128, 128, -127872);
        add_point(0, 0, 8388607);
        add_random_points(200);
        drain();

        // Random settings.
        write_all(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
                  rand_focal(), rand48());
        add_random_points(200);
        drain();

        // Upper extremes.
        write_all('1, '1, '1, 48'h7F_FFFF, 48'h7F_FFFF, 48'h7F_FFFF, '1, '1);
        add_point(0, 0, 0);
        add_point(8388607, 8388607, 8388607);
        add_point(-8388608, -8388608, -8388608);
        add_random_points(100);
        drain();

        // Lower extremes.
        write_all(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                  48'h80_0000, 48'h80_0000, 48'h80_0000, '0, '0);
        add_point(0, 0, 0);
        add_point(8388607, 8388607, 8388607);
        add_point(-8388608, -8388608, -8388608);
        add_random_points(100);
        drain();

        // Identity depth row so the depth plane is hit often.
        for (int ph = 0; ph < 5; ph++) begin
            write_all(rand48(), rand48(), 48'h0000_0000_4000,
                      rand48(), rand48(), 48'(24'($urandom_range(0, 1 << 20) - (1 << 19))),
                      ph == 0 ? '1 : rand_focal(), rand48());
            add_random_points((RANDOM_ITEMS - 600) / 5);
            drain();
        end

        if (mismatches == 0) begin
            $display("pinhole_point_projection test passed");
        end else begin
            $display("pinhole_point_projection test failed");
        end
        $finish;
    end
endmodule

// File: pinhole_point_projection.f
sv/ppp_pkg.sv
sv/pinhole_point_projection.sv
tb/sv/testbench.sv
